### rtl/core/obld_pkg.sv
package obld_pkg;

  localparam int unsigned PRICE_W = 32;
  localparam int unsigned VOL_W   = 31;
  localparam int unsigned DVOL_W  = 32;
  localparam int unsigned SLOT_W  = 4;

  // Side codes of a result slot.
  localparam logic SIDE_BID = 1'b0;
  localparam logic SIDE_ASK = 1'b1;

  // One level of both snapshots as it arrives.
  typedef struct packed {
    logic [PRICE_W-1:0] old_bid_price;
    logic [VOL_W-1:0]   old_bid_volume;
    logic [PRICE_W-1:0] old_ask_price;
    logic [VOL_W-1:0]   old_ask_volume;
    logic [PRICE_W-1:0] new_bid_price;
    logic [VOL_W-1:0]   new_bid_volume;
    logic [PRICE_W-1:0] new_ask_price;
    logic [VOL_W-1:0]   new_ask_volume;
  } level_t;

  // One merged delta slot.
  typedef struct packed {
    logic                      side;
    logic [SLOT_W-1:0]         slot;
    logic [PRICE_W-1:0]        delta_price;
    logic signed [DVOL_W-1:0]  delta_volume;
    logic                      last_result;
  } result_t;

  // True when price a comes before price b on the given side.
  function automatic logic ahead(logic side, logic [PRICE_W-1:0] a, logic [PRICE_W-1:0] b);
    ahead = (side == SIDE_ASK) ? (a < b) : (a > b);
  endfunction

endpackage

### rtl/core/obld_if.sv
// Level channel: one level of the old and the new snapshot per transaction.
interface obld_level_if;
  logic        valid;
  logic        ready;
  logic [31:0] old_bid_price;
  logic [30:0] old_bid_volume;
  logic [31:0] old_ask_price;
  logic [30:0] old_ask_volume;
  logic [31:0] new_bid_price;
  logic [30:0] new_bid_volume;
  logic [31:0] new_ask_price;
  logic [30:0] new_ask_volume;
  logic        last_level;

  modport source (
    output valid, old_bid_price, old_bid_volume, old_ask_price, old_ask_volume,
           new_bid_price, new_bid_volume, new_ask_price, new_ask_volume, last_level,
    input  ready
  );
  modport sink (
    input  valid, old_bid_price, old_bid_volume, old_ask_price, old_ask_volume,
           new_bid_price, new_bid_volume, new_ask_price, new_ask_volume, last_level,
    output ready
  );
endinterface

// Delta channel: one merged slot per transaction.
interface obld_delta_if;
  logic        valid;
  logic        ready;
  logic        side;
  logic [3:0]  slot;
  logic [31:0] delta_price;
  logic signed [31:0] delta_volume;
  logic        last_result;

  modport source (
    output valid, side, slot, delta_price, delta_volume, last_result,
    input  ready
  );
  modport sink (
    input  valid, side, slot, delta_price, delta_volume, last_result,
    output ready
  );
endinterface

### rtl/core/obld_front.sv
module obld_front #(
  parameter int unsigned LEVELS = 5,
  parameter int unsigned IW     = 3,
  parameter int unsigned EW     = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  obld_pkg::level_t in_level_i,
  input  logic            in_last_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output logic [EW-1:0]   push_data_o
);
  import obld_pkg::*;

  localparam int unsigned CW = $clog2(LEVELS + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          store;
  logic          accept;

  // A level is stored only while the run has room for it.
  assign store        = (cnt_q < CW'(LEVELS));
  assign accept       = in_valid_i && push_ready_i;
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign push_data_o  = {in_level_i, cnt_q[IW-1:0], store, in_last_i};

  // Level counter saturates at the depth and restarts after the last level.
  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      if (in_last_i) begin
        cnt_d = '0;
      end else if (store) begin
        cnt_d = cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

### rtl/core/obld_queue.sv
module obld_queue #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);

  logic [W-1:0] mem_q [2];
  logic         wptr_q, rptr_q;
  logic [1:0]   cnt_q;
  logic         push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_data_o   = mem_q[rptr_q];

  // Two-entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

### rtl/core/obld_back.sv
module obld_back #(
  parameter int unsigned LEVELS = 5,
  parameter int unsigned IW     = 3,
  parameter int unsigned EW     = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  output logic             q_pop_o,
  input  logic [EW-1:0]    q_data_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output obld_pkg::result_t res_o
);
  import obld_pkg::*;

  localparam int unsigned CW    = $clog2(LEVELS + 1);
  localparam int unsigned SLOTS = 2 * LEVELS;
  localparam int unsigned KW    = $clog2(SLOTS);
  localparam int unsigned LW    = $bits(level_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SKIP_OLD,
    ST_SKIP_NEW,
    ST_MERGE
  } state_e;

  state_e        state_q, state_d;
  logic          side_q, side_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d;
  logic [KW-1:0] k_q, k_d;
  logic          out_valid_q, out_valid_d;
  result_t       res_q, res_d;

  // Level stores, indexed by side then level.
  logic [PRICE_W-1:0] old_price_q [2][LEVELS];
  logic [VOL_W-1:0]   old_vol_q   [2][LEVELS];
  logic [PRICE_W-1:0] new_price_q [2][LEVELS];
  logic [VOL_W-1:0]   new_vol_q   [2][LEVELS];

  level_t        q_level;
  logic [IW-1:0] q_idx;
  logic          q_store, q_last;

  logic [PRICE_W-1:0] op_i, np_j, op_0, np_0, merged_price;
  logic [VOL_W-1:0]   ov_i, nv_j;
  logic [DVOL_W-1:0]  vol_new, vol_old;
  logic               i_ok, j_ok, fill, hit_old, hit_new, k_last;
  logic               out_free, out_load, wr_en;
  logic [31:0]        k_ext;

  // Unpack the queue entry.
  assign q_level = q_data_i[EW-1 -: LW];
  assign q_idx   = q_data_i[IW+1:2];
  assign q_store = q_data_i[1];
  assign q_last  = q_data_i[0];

  // Heads and cursors of the two books on the active side.
  assign op_i = old_price_q[side_q][i_q[IW-1:0]];
  assign ov_i = old_vol_q[side_q][i_q[IW-1:0]];
  assign np_j = new_price_q[side_q][j_q[IW-1:0]];
  assign nv_j = new_vol_q[side_q][j_q[IW-1:0]];
  assign op_0 = old_price_q[side_q][0];
  assign np_0 = new_price_q[side_q][0];

  assign i_ok   = (i_q < CW'(LEVELS));
  assign j_ok   = (j_q < CW'(LEVELS));
  assign fill   = i_ok && j_ok;
  assign k_last = (k_q == KW'(SLOTS - 1));

  // One merge step: pick the leading price and combine volumes at it.
  assign merged_price = ahead(side_q, op_i, np_j) ? op_i : np_j;
  assign hit_old      = (merged_price == op_i);
  assign hit_new      = (merged_price == np_j);
  assign vol_new      = hit_new ? {1'b0, nv_j} : '0;
  assign vol_old      = hit_old ? {1'b0, ov_i} : '0;
  assign k_ext        = 32'(k_q);

  assign out_free    = !out_valid_q || res_ready_i;
  assign q_pop_o     = (state_q == ST_IDLE);
  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

  // Sequencer for loading, skipping and merging.
  always_comb begin
    state_d  = state_q;
    side_d   = side_q;
    i_d      = i_q;
    j_d      = j_q;
    k_d      = k_q;
    out_load = 1'b0;
    wr_en    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          wr_en = q_store;
          if (q_last) begin
            side_d  = SIDE_BID;
            i_d     = '0;
            state_d = ST_SKIP_OLD;
          end
        end
      end
      ST_SKIP_OLD: begin
        if (i_ok && ahead(side_q, op_i, np_0)) begin
          i_d = i_q + CW'(1);
        end else begin
          j_d     = '0;
          state_d = ST_SKIP_NEW;
        end
      end
      ST_SKIP_NEW: begin
        if (j_ok && ahead(side_q, np_j, op_0)) begin
          j_d = j_q + CW'(1);
        end else begin
          k_d     = '0;
          state_d = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (out_free) begin
          out_load = 1'b1;
          if (fill) begin
            if (hit_old) begin
              i_d = i_q + CW'(1);
            end
            if (hit_new) begin
              j_d = j_q + CW'(1);
            end
          end
          if (k_last) begin
            if (side_q == SIDE_BID) begin
              side_d  = SIDE_ASK;
              i_d     = '0;
              state_d = ST_SKIP_OLD;
            end else begin
              state_d = ST_IDLE;
            end
          end else begin
            k_d = k_q + KW'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Next slot for the output register.
  always_comb begin
    res_d.side         = side_q;
    res_d.slot         = k_ext[SLOT_W-1:0];
    res_d.delta_price  = fill ? merged_price : '0;
    res_d.delta_volume = fill ? signed'(vol_new - vol_old) : '0;
    res_d.last_result  = (side_q == SIDE_ASK) && k_last;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      side_q      <= SIDE_BID;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      side_q      <= side_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload of the output register and the level stores.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q <= res_d;
    end
    if (wr_en) begin
      old_price_q[SIDE_BID][q_idx] <= q_level.old_bid_price;
      old_vol_q[SIDE_BID][q_idx]   <= q_level.old_bid_volume;
      new_price_q[SIDE_BID][q_idx] <= q_level.new_bid_price;
      new_vol_q[SIDE_BID][q_idx]   <= q_level.new_bid_volume;
      old_price_q[SIDE_ASK][q_idx] <= q_level.old_ask_price;
      old_vol_q[SIDE_ASK][q_idx]   <= q_level.old_ask_volume;
      new_price_q[SIDE_ASK][q_idx] <= q_level.new_ask_price;
      new_vol_q[SIDE_ASK][q_idx]   <= q_level.new_ask_volume;
    end
  end

endmodule

### rtl/core/order_book_level_delta.sv
// Order book level delta.
// The level channel in_i carries one level of an old and a new snapshot per
// transaction; last_level marks the final level of a run and starts the merge.
// Up to LEVELS levels are stored per run, and further levels before the last
// one are dropped. The delta channel out_o then carries 2*LEVELS slots for the
// bid side followed by 2*LEVELS slots for the ask side; last_result marks the
// final ask slot. Unfilled slots carry a zero price and a zero volume.
// Levels pass a two-entry queue to the merge engine, which takes levels back
// to back while it is idle. After the last level the engine runs, per side,
// a skip scan over the old book and one over the new book, then a merge loop
// that loads one slot per cycle into the output register while the receiver
// does not stall. The first slot follows the two skip scans of the bid side.
// Reset clears the level counter, the queue and the engine; the level stores
// keep no reset value. When the receiver stalls, the current slot holds in
// the output register and the merge pauses. The queue is popped only while
// the engine is loading, so otherwise it fills and in_i drops ready until
// the engine returns to loading.
module order_book_level_delta #(
  parameter int unsigned LEVELS = 5
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  obld_level_if.sink   in_i,
  obld_delta_if.source out_o
);
  import obld_pkg::*;

  localparam int unsigned IW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned EW    = $bits(level_t) + IW + 2;
  localparam int unsigned SLOTS = 2 * LEVELS;
  localparam logic [31:0] LAST_SLOT = 32'(SLOTS - 1);

  level_t        in_level;
  logic          push_valid, push_ready, pop_valid, pop_ready;
  logic [EW-1:0] push_data, pop_data;
  result_t       res;

  // Gather the input payload.
  assign in_level.old_bid_price  = in_i.old_bid_price;
  assign in_level.old_bid_volume = in_i.old_bid_volume;
  assign in_level.old_ask_price  = in_i.old_ask_price;
  assign in_level.old_ask_volume = in_i.old_ask_volume;
  assign in_level.new_bid_price  = in_i.new_bid_price;
  assign in_level.new_bid_volume = in_i.new_bid_volume;
  assign in_level.new_ask_price  = in_i.new_ask_price;
  assign in_level.new_ask_volume = in_i.new_ask_volume;

  obld_front #(
    .LEVELS (LEVELS),
    .IW     (IW),
    .EW     (EW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_level_i   (in_level),
    .in_last_i    (in_i.last_level),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  obld_queue #(
    .W (EW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  obld_back #(
    .LEVELS (LEVELS),
    .IW     (IW),
    .EW     (EW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (pop_valid),
    .q_pop_o     (pop_ready),
    .q_data_i    (pop_data),
    .res_valid_o (out_o.valid),
    .res_ready_i (out_o.ready),
    .res_o       (res)
  );

  // Drive the delta payload.
  assign out_o.side         = res.side;
  assign out_o.slot         = res.slot;
  assign out_o.delta_price  = res.delta_price;
  assign out_o.delta_volume = res.delta_volume;
  assign out_o.last_result  = res.last_result;

`ifndef SYNTH
  // The closing slot of a run is the top ask slot.
  a_last_is_top_ask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.last_result |->
      (out_o.side == SIDE_ASK) && (out_o.slot == LAST_SLOT[SLOT_W-1:0]))
    else $error("last_result on a slot other than the final ask slot");

  // A slot that is not taken stays on the channel unchanged.
  a_hold_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(res))
    else $error("slot changed or dropped while the receiver stalled");
`endif

endmodule
